[rtl/core/whp_pkg.sv]
package whp_pkg;

  localparam int unsigned QUOT_W = 42;
  localparam int unsigned DVSR_W = 32;
  localparam int unsigned CNT_W  = $clog2(QUOT_W + 1);

  typedef enum logic [3:0] {
    PH_RIFF,
    PH_RSIZE,
    PH_WAVE,
    PH_TAG1,
    PH_SIZE1,
    PH_SKIP1,
    PH_FMT,
    PH_TAG2,
    PH_SIZE2,
    PH_SKIP2,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    C_RUN,
    C_S1,
    C_W1,
    C_MUL,
    C_S2,
    C_W2,
    C_OUT
  } cstate_t;

  localparam logic [3:0] ST_OK    = 4'd0;
  localparam logic [3:0] ST_MARK  = 4'd1;
  localparam logic [3:0] ST_TRUNC = 4'd2;
  localparam logic [3:0] ST_TAG   = 4'd3;
  localparam logic [3:0] ST_EXT   = 4'd4;
  localparam logic [3:0] ST_DEPTH = 4'd5;
  localparam logic [3:0] ST_ALIGN = 4'd6;
  localparam logic [3:0] ST_LONG  = 4'd7;
  localparam logic [3:0] ST_ZERO  = 4'd8;

  localparam logic [1:0] FK_PCM   = 2'd0;
  localparam logic [1:0] FK_FLOAT = 2'd1;
  localparam logic [1:0] FK_EXT   = 2'd2;

  localparam logic [15:0] TAG_PCM   = 16'h0001;
  localparam logic [15:0] TAG_FLOAT = 16'h0003;
  localparam logic [15:0] TAG_EXT   = 16'hFFFE;

  localparam logic [31:0] MARK_RIFF = 32'h4646_4952;
  localparam logic [31:0] MARK_WAVE = 32'h4556_4157;
  localparam logic [31:0] MARK_FMT  = 32'h2074_6d66;
  localparam logic [31:0] MARK_DATA = 32'h6174_6164;

  localparam logic [15:0] EXT_CB_LEN  = 16'd22;
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;
  localparam logic [31:0] EXT_MIN_LEN = 32'd40;
  localparam logic [5:0]  FMT_POS_END = 6'd40;
  localparam logic [9:0]  MS_SCALE    = 10'd1000;

  typedef struct packed {
    logic byte_acc;
    logic samp_load;
    logic mul_load;
    logic ms_load;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic ok;
  } dp_stat_t;

  function automatic logic [7:0] guid_pcm_byte(input logic [3:0] idx);
    logic [7:0] val;
    case (idx)
      4'd0:    val = 8'h01;
      4'd6:    val = 8'h10;
      4'd8:    val = 8'h80;
      4'd11:   val = 8'haa;
      4'd13:   val = 8'h38;
      4'd14:   val = 8'h9b;
      4'd15:   val = 8'h71;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic logic [7:0] guid_float_byte(input logic [3:0] idx);
    logic [7:0] val;
    val = (idx == 4'd0) ? 8'h03 : guid_pcm_byte(idx);
    return val;
  endfunction

endpackage

[rtl/core/whp_div.sv]
module whp_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [whp_pkg::QUOT_W-1:0]   dividend,
  input  logic [whp_pkg::DVSR_W-1:0]   divisor,
  output logic                         done,
  output logic [whp_pkg::QUOT_W-1:0]   quot
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [whp_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [whp_pkg::QUOT_W-1:0]  q_r, q_nxt;
  logic [whp_pkg::DVSR_W-1:0]  rem_r, rem_nxt;
  logic [whp_pkg::DVSR_W-1:0]  dvs_r, dvs_nxt;
  logic [whp_pkg::DVSR_W:0]    trial;
  logic                        ge;

  assign trial = {rem_r, q_r[whp_pkg::QUOT_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = whp_pkg::CNT_W'(whp_pkg::QUOT_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? whp_pkg::DVSR_W'(trial - {1'b0, dvs_r})
                   : trial[whp_pkg::DVSR_W-1:0];
      q_nxt   = {q_r[whp_pkg::QUOT_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == whp_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

[rtl/core/whp_dp.sv]
module whp_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  in_file_byte,
  input  logic                        in_first_byte,
  input  logic                        in_last_byte,
  input  logic                        cfg_wr_en,
  input  logic [31:0]                 cfg_wr_data,
  input  whp_pkg::dp_cmd_t            cmd,
  output whp_pkg::dp_stat_t           stat,
  input  logic [whp_pkg::QUOT_W-1:0]  div_q,
  output logic [whp_pkg::QUOT_W-1:0]  div_a,
  output logic [whp_pkg::DVSR_W-1:0]  div_b,
  output logic [3:0]                  out_status,
  output logic [15:0]                 out_channels,
  output logic [31:0]                 out_sample_rate,
  output logic [5:0]                  out_valid_bits,
  output logic [2:0]                  out_container_bytes,
  output logic                        out_is_float,
  output logic [31:0]                 out_speaker_mask,
  output logic [31:0]                 out_data_offset,
  output logic [31:0]                 out_total_samples,
  output logic [41:0]                 out_total_time_ms
);

  whp_pkg::phase_t phase_r, phase_nxt, ph_cur;
  logic [31:0] flen_r;
  logic [31:0] off_r, off_nxt, off_cur;
  logic [1:0]  fcnt_r, fcnt_nxt, fc_cur;
  logic        fin_r, fin_nxt, fin_cur;
  logic [31:0] shift_r, shift_nxt, sh_new;
  logic [31:0] rem_r, rem_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [31:0] fmtlen_r, fmtlen_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic        isfmt_r, isfmt_nxt;
  logic        isdata_r, isdata_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] align_r, align_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic [15:0] cb_r, cb_nxt;
  logic [15:0] valid_r, valid_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [1:0]  guid_r, guid_nxt;
  logic [31:0] dsize_r, dsize_nxt;
  logic [2:0]  cont_r, cont_nxt;
  logic        flt_r, flt_nxt;
  logic [18:0] divisor_r;
  logic [21:0] div_prod;
  logic [41:0] ms_prod;

  logic        ev_err, ev_ok, fin_fmt;
  logic [3:0]  ev_code, fmt_st;
  logic [15:0] tag, fmt_v;
  logic        fmt_isf;
  logic [32:0] start, flen33;
  logic [3:0]  gidx;

  function automatic logic [3:0] fmt_check(
    input logic [31:0] flen_f,
    input logic [1:0]  kind,
    input logic [15:0] cb,
    input logic [15:0] bits,
    input logic [15:0] valid,
    input logic [1:0]  guid,
    input logic [15:0] align,
    input logic [15:0] ch
  );
    logic [15:0] v;
    logic [12:0] c;
    logic        ext;
    logic        isf;
    logic [18:0] prod;
    logic [3:0]  st;
    ext  = kind == whp_pkg::FK_EXT;
    c    = bits[15:3];
    v    = ext ? valid : bits;
    isf  = ext ? !guid[0] : (kind == whp_pkg::FK_FLOAT);
    prod = 19'(c[2:0]) * 19'(ch);
    if (flen_f < whp_pkg::FMT_MIN_LEN)
      st = whp_pkg::ST_TRUNC;
    else if (ext && (flen_f < whp_pkg::EXT_MIN_LEN || cb != whp_pkg::EXT_CB_LEN))
      st = whp_pkg::ST_EXT;
    else if (bits[2:0] != 3'd0)
      st = whp_pkg::ST_DEPTH;
    else if (ext && guid == 2'b00)
      st = whp_pkg::ST_EXT;
    else if (v > 16'd32 || v < 16'd8)
      st = whp_pkg::ST_DEPTH;
    else if (v > bits)
      st = whp_pkg::ST_DEPTH;
    else if (c > 13'd4)
      st = whp_pkg::ST_DEPTH;
    else if (isf && (v != 16'd32 || c != 13'd4))
      st = whp_pkg::ST_DEPTH;
    else if ({3'd0, align} != prod)
      st = whp_pkg::ST_ALIGN;
    else
      st = whp_pkg::ST_OK;
    return st;
  endfunction

  assign ph_cur  = in_first_byte ? whp_pkg::PH_RIFF : phase_r;
  assign off_cur = in_first_byte ? 32'd0 : off_r;
  assign fc_cur  = in_first_byte ? 2'd0 : fcnt_r;
  assign fin_cur = in_first_byte ? 1'b0 : fin_r;
  assign sh_new  = {in_file_byte, shift_r[31:8]};
  assign start   = {1'b0, off_cur} + 33'd1;
  assign flen33  = {1'b0, flen_r};
  assign gidx    = pos_r[3:0] + 4'd8;
  assign div_prod = 22'(ch_r) * 22'(valid_r[5:0]);
  assign ms_prod  = 42'(out_total_samples) * 42'(whp_pkg::MS_SCALE);

  always_comb begin
    phase_nxt  = phase_r;
    off_nxt    = off_r;
    fcnt_nxt   = fc_cur;
    fin_nxt    = fin_cur;
    shift_nxt  = shift_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    fmtlen_nxt = fmtlen_r;
    kind_nxt   = kind_r;
    isfmt_nxt  = isfmt_r;
    isdata_nxt = isdata_r;
    ch_nxt     = ch_r;
    rate_nxt   = rate_r;
    align_nxt  = align_r;
    bits_nxt   = bits_r;
    cb_nxt     = cb_r;
    valid_nxt  = valid_r;
    mask_nxt   = mask_r;
    guid_nxt   = guid_r;
    dsize_nxt  = dsize_r;
    cont_nxt   = cont_r;
    flt_nxt    = flt_r;
    ev_err     = 1'b0;
    ev_ok      = 1'b0;
    ev_code    = whp_pkg::ST_OK;
    fin_fmt    = 1'b0;
    fmt_st     = whp_pkg::ST_OK;
    tag        = {in_file_byte, shift_r[7:0]};
    fmt_v      = 16'd0;
    fmt_isf    = 1'b0;
    if (in_first_byte) begin
      phase_nxt = whp_pkg::PH_RIFF;
      off_nxt   = 32'd0;
    end
    if (!fin_cur) begin
      case (ph_cur)
        whp_pkg::PH_FMT: begin
          if (pos_r == 6'd0) begin
            shift_nxt = {24'd0, in_file_byte};
          end else if (pos_r == 6'd1) begin
            if (tag == whp_pkg::TAG_PCM) begin
              kind_nxt = whp_pkg::FK_PCM;
            end else if (tag == whp_pkg::TAG_FLOAT) begin
              kind_nxt = whp_pkg::FK_FLOAT;
            end else if (tag == whp_pkg::TAG_EXT) begin
              kind_nxt = whp_pkg::FK_EXT;
            end else begin
              ev_err  = 1'b1;
              ev_code = whp_pkg::ST_TAG;
            end
          end else if (pos_r < 6'd4) begin
            ch_nxt[8*pos_r[0] +: 8] = in_file_byte;
          end else if (pos_r < 6'd8) begin
            rate_nxt[8*pos_r[1:0] +: 8] = in_file_byte;
          end else if (pos_r < 6'd12) begin
            rate_nxt = rate_r;
          end else if (pos_r < 6'd14) begin
            align_nxt[8*pos_r[0] +: 8] = in_file_byte;
          end else if (pos_r < 6'd16) begin
            bits_nxt[8*pos_r[0] +: 8] = in_file_byte;
          end else if (pos_r < 6'd18) begin
            cb_nxt[8*pos_r[0] +: 8] = in_file_byte;
          end else if (pos_r < 6'd20) begin
            valid_nxt[8*pos_r[0] +: 8] = in_file_byte;
          end else if (pos_r < 6'd24) begin
            mask_nxt[8*pos_r[1:0] +: 8] = in_file_byte;
          end else if (pos_r < whp_pkg::FMT_POS_END) begin
            if (in_file_byte != whp_pkg::guid_pcm_byte(gidx)) guid_nxt[0] = 1'b0;
            if (in_file_byte != whp_pkg::guid_float_byte(gidx)) guid_nxt[1] = 1'b0;
          end
          if (!ev_err) begin
            if (pos_r < whp_pkg::FMT_POS_END) pos_nxt = pos_r + 6'd1;
            rem_nxt = rem_r - 32'd1;
            if (rem_nxt == 32'd0) fin_fmt = 1'b1;
          end
        end
        whp_pkg::PH_SKIP1, whp_pkg::PH_SKIP2: begin
          rem_nxt = rem_r - 32'd1;
          if (rem_nxt == 32'd0) begin
            phase_nxt = (ph_cur == whp_pkg::PH_SKIP1) ? whp_pkg::PH_TAG1 : whp_pkg::PH_TAG2;
            fcnt_nxt  = 2'd0;
          end
        end
        default: begin
          shift_nxt = sh_new;
          fcnt_nxt  = fc_cur + 2'd1;
          if (fc_cur == 2'd3) begin
            case (ph_cur)
              whp_pkg::PH_RIFF: begin
                if (sh_new != whp_pkg::MARK_RIFF) begin
                  ev_err  = 1'b1;
                  ev_code = whp_pkg::ST_MARK;
                end else begin
                  phase_nxt = whp_pkg::PH_RSIZE;
                end
              end
              whp_pkg::PH_RSIZE: phase_nxt = whp_pkg::PH_WAVE;
              whp_pkg::PH_WAVE: begin
                if (sh_new != whp_pkg::MARK_WAVE) begin
                  ev_err  = 1'b1;
                  ev_code = whp_pkg::ST_MARK;
                end else begin
                  phase_nxt = whp_pkg::PH_TAG1;
                end
              end
              whp_pkg::PH_TAG1: begin
                isfmt_nxt = sh_new == whp_pkg::MARK_FMT;
                phase_nxt = whp_pkg::PH_SIZE1;
              end
              whp_pkg::PH_SIZE1: begin
                rem_nxt = sh_new;
                if (isfmt_r) begin
                  fmtlen_nxt = sh_new;
                  pos_nxt    = 6'd0;
                  kind_nxt   = whp_pkg::FK_PCM;
                  ch_nxt     = 16'd0;
                  rate_nxt   = 32'd0;
                  align_nxt  = 16'd0;
                  bits_nxt   = 16'd0;
                  cb_nxt     = 16'd0;
                  valid_nxt  = 16'd0;
                  mask_nxt   = 32'd0;
                  guid_nxt   = 2'b11;
                  phase_nxt  = whp_pkg::PH_FMT;
                  if (sh_new == 32'd0) begin
                    ev_err  = 1'b1;
                    ev_code = whp_pkg::ST_TRUNC;
                  end
                end else begin
                  phase_nxt = (sh_new != 32'd0) ? whp_pkg::PH_SKIP1 : whp_pkg::PH_TAG1;
                end
              end
              whp_pkg::PH_TAG2: begin
                isdata_nxt = sh_new == whp_pkg::MARK_DATA;
                phase_nxt  = whp_pkg::PH_SIZE2;
              end
              whp_pkg::PH_SIZE2: begin
                if (isdata_r) begin
                  dsize_nxt = sh_new;
                  if (flen33 < start || {1'b0, sh_new} > flen33 - start) begin
                    ev_err  = 1'b1;
                    ev_code = whp_pkg::ST_LONG;
                  end else if (divisor_r == 19'd0 || rate_r == 32'd0) begin
                    ev_err  = 1'b1;
                    ev_code = whp_pkg::ST_ZERO;
                  end else begin
                    ev_ok = 1'b1;
                  end
                end else begin
                  rem_nxt   = sh_new;
                  phase_nxt = (sh_new != 32'd0) ? whp_pkg::PH_SKIP2 : whp_pkg::PH_TAG2;
                end
              end
              default: phase_nxt = phase_r;
            endcase
          end
        end
      endcase
      if (fin_fmt) begin
        fmt_st = fmt_check(fmtlen_nxt, kind_nxt, cb_nxt, bits_nxt, valid_nxt, guid_nxt,
                           align_nxt, ch_nxt);
        fmt_v   = (kind_nxt == whp_pkg::FK_EXT) ? valid_nxt : bits_nxt;
        fmt_isf = (kind_nxt == whp_pkg::FK_EXT) ? !guid_nxt[0]
                                                : (kind_nxt == whp_pkg::FK_FLOAT);
        if (fmt_st != whp_pkg::ST_OK) begin
          ev_err  = 1'b1;
          ev_code = fmt_st;
        end else begin
          phase_nxt = whp_pkg::PH_TAG2;
          fcnt_nxt  = 2'd0;
          valid_nxt = fmt_v;
          cont_nxt  = bits_nxt[5:3];
          flt_nxt   = fmt_isf;
          if (kind_nxt != whp_pkg::FK_EXT) mask_nxt = 32'd0;
        end
      end
      off_nxt = off_cur + 32'd1;
      if (!ev_err && !ev_ok && in_last_byte) begin
        ev_err  = 1'b1;
        ev_code = whp_pkg::ST_TRUNC;
      end
      if (ev_err || ev_ok) begin
        fin_nxt   = 1'b1;
        phase_nxt = whp_pkg::PH_DONE;
      end
    end
  end

  assign stat.err = ev_err;
  assign stat.ok  = ev_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flen_r  <= 32'd0;
      phase_r <= whp_pkg::PH_RIFF;
      off_r   <= 32'd0;
      fcnt_r  <= 2'd0;
      fin_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) flen_r <= cfg_wr_data;
      if (cmd.byte_acc) begin
        phase_r <= phase_nxt;
        off_r   <= off_nxt;
        fcnt_r  <= fcnt_nxt;
        fin_r   <= fin_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    divisor_r <= div_prod[21:3];
    if (cmd.byte_acc) begin
      shift_r  <= shift_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      fmtlen_r <= fmtlen_nxt;
      kind_r   <= kind_nxt;
      isfmt_r  <= isfmt_nxt;
      isdata_r <= isdata_nxt;
      ch_r     <= ch_nxt;
      rate_r   <= rate_nxt;
      align_r  <= align_nxt;
      bits_r   <= bits_nxt;
      cb_r     <= cb_nxt;
      valid_r  <= valid_nxt;
      mask_r   <= mask_nxt;
      guid_r   <= guid_nxt;
      dsize_r  <= dsize_nxt;
      cont_r   <= cont_nxt;
      flt_r    <= flt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.byte_acc && ev_err) begin
      out_status          <= ev_code;
      out_channels        <= 16'd0;
      out_sample_rate     <= 32'd0;
      out_valid_bits      <= 6'd0;
      out_container_bytes <= 3'd0;
      out_is_float        <= 1'b0;
      out_speaker_mask    <= 32'd0;
      out_data_offset     <= 32'd0;
      out_total_samples   <= 32'd0;
      out_total_time_ms   <= 42'd0;
    end else if (cmd.byte_acc && ev_ok) begin
      out_status          <= whp_pkg::ST_OK;
      out_channels        <= ch_r;
      out_sample_rate     <= rate_r;
      out_valid_bits      <= valid_r[5:0];
      out_container_bytes <= cont_r;
      out_is_float        <= flt_r;
      out_speaker_mask    <= mask_r;
      out_data_offset     <= start[31:0];
      div_a               <= {10'd0, sh_new};
      div_b               <= {13'd0, divisor_r};
    end
    if (cmd.samp_load) out_total_samples <= div_q[31:0];
    if (cmd.mul_load) begin
      div_a <= ms_prod;
      div_b <= rate_r;
    end
    if (cmd.ms_load) out_total_time_ms <= div_q;
  end

endmodule

[rtl/core/whp_ctrl.sv]
module whp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  whp_pkg::dp_stat_t stat,
  output whp_pkg::dp_cmd_t  cmd,
  output logic              div_start,
  input  logic              div_done
);

  whp_pkg::cstate_t state_r, state_nxt;
  logic accept;

  assign accept = in_valid && (state_r == whp_pkg::C_RUN);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      whp_pkg::C_RUN: begin
        if (accept && stat.err) state_nxt = whp_pkg::C_OUT;
        else if (accept && stat.ok) state_nxt = whp_pkg::C_S1;
      end
      whp_pkg::C_S1:  state_nxt = whp_pkg::C_W1;
      whp_pkg::C_W1:  if (div_done) state_nxt = whp_pkg::C_MUL;
      whp_pkg::C_MUL: state_nxt = whp_pkg::C_S2;
      whp_pkg::C_S2:  state_nxt = whp_pkg::C_W2;
      whp_pkg::C_W2:  if (div_done) state_nxt = whp_pkg::C_OUT;
      whp_pkg::C_OUT: if (!out_stall) state_nxt = whp_pkg::C_RUN;
      default:        state_nxt = whp_pkg::C_RUN;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    out_valid     = 1'b0;
    div_start     = 1'b0;
    cmd.byte_acc  = 1'b0;
    cmd.samp_load = 1'b0;
    cmd.mul_load  = 1'b0;
    cmd.ms_load   = 1'b0;
    case (state_r)
      whp_pkg::C_RUN: begin
        in_stall     = 1'b0;
        cmd.byte_acc = accept;
      end
      whp_pkg::C_S1, whp_pkg::C_S2: div_start = 1'b1;
      whp_pkg::C_W1:  cmd.samp_load = div_done;
      whp_pkg::C_MUL: cmd.mul_load = 1'b1;
      whp_pkg::C_W2:  cmd.ms_load = div_done;
      whp_pkg::C_OUT: out_valid = 1'b1;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= whp_pkg::C_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/wave_header_parser.sv]
// RIFF WAVE header parser. Feed the file one byte per beat from offset zero,
// marking offset zero with in_first_byte and the final byte with in_last_byte;
// file_length must be written before the file starts. While parsing, one
// byte is taken every cycle. Each file yields exactly one result beat: on the
// first error (all fields but status zero) or, for a good header, after the
// four size bytes of the data chunk. For a good header the shared bit-serial
// divider then runs two 42-step divisions (sample count, then duration in ms).
// Input stays stalled from the byte that produces a result until the result
// beat is taken; bytes after the result are dropped until the next
// in_first_byte.
module wave_header_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_file_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [15:0] out_channels,
  output logic [31:0] out_sample_rate,
  output logic [5:0]  out_valid_bits,
  output logic [2:0]  out_container_bytes,
  output logic        out_is_float,
  output logic [31:0] out_speaker_mask,
  output logic [31:0] out_data_offset,
  output logic [31:0] out_total_samples,
  output logic [41:0] out_total_time_ms,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  whp_pkg::dp_cmd_t             cmd;
  whp_pkg::dp_stat_t            stat;
  logic                         div_start;
  logic                         div_done;
  logic [whp_pkg::QUOT_W-1:0]   div_q;
  logic [whp_pkg::QUOT_W-1:0]   div_a;
  logic [whp_pkg::DVSR_W-1:0]   div_b;

  whp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .div_start (div_start),
    .div_done  (div_done)
  );

  whp_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_file_byte        (in_file_byte),
    .in_first_byte       (in_first_byte),
    .in_last_byte        (in_last_byte),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .stat                (stat),
    .div_q               (div_q),
    .div_a               (div_a),
    .div_b               (div_b),
    .out_status          (out_status),
    .out_channels        (out_channels),
    .out_sample_rate     (out_sample_rate),
    .out_valid_bits      (out_valid_bits),
    .out_container_bytes (out_container_bytes),
    .out_is_float        (out_is_float),
    .out_speaker_mask    (out_speaker_mask),
    .out_data_offset     (out_data_offset),
    .out_total_samples   (out_total_samples),
    .out_total_time_ms   (out_total_time_ms)
  );

  whp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q)
  );

endmodule

[rtl/core/whp_check.sv]
module whp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  out_status,
  input logic [15:0] out_channels,
  input logic [31:0] out_sample_rate,
  input logic [5:0]  out_valid_bits,
  input logic [2:0]  out_container_bytes,
  input logic        out_is_float,
  input logic [31:0] out_speaker_mask,
  input logic [31:0] out_data_offset,
  input logic [31:0] out_total_samples,
  input logic [41:0] out_total_time_ms
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_total_time_ms))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != whp_pkg::ST_OK |-> out_channels == 16'd0
      && out_sample_rate == 32'd0 && out_data_offset == 32'd0
      && out_total_samples == 32'd0 && out_total_time_ms == 42'd0
      && out_is_float == 1'b0 && out_speaker_mask == 32'd0)
    else $error("error result carries nonzero fields");

  a_ok_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == whp_pkg::ST_OK |-> out_valid_bits >= 6'd8
      && out_valid_bits <= 6'd32 && out_container_bytes >= 3'd1
      && out_container_bytes <= 3'd4 && out_sample_rate != 32'd0)
    else $error("good result with impossible format");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= whp_pkg::ST_ZERO)
    else $error("status code out of range");

endmodule

bind wave_header_parser whp_check u_whp_check (.*);
